FILE: rtl/core/bhpq_pkg.sv
`default_nettype none
package bhpq_pkg;

  localparam int CAPACITY = 64;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int IW       = AW + 2;
  localparam int VAL_W    = 32;
  localparam int COUNT_W  = 7;
  localparam int ST_W     = 2;
  localparam int OUT_RAW  = ST_W + VAL_W + VAL_W + COUNT_W;
  localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8;
  localparam int IN_W     = VAL_W;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_PARENT,
    RD_LAST,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_CUR,
    WR_PARENT,
    WR_CHILD
  } wr_sel_t;

  typedef struct packed {
    logic    accept;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    cap_left;
    logic    cap_right;
    logic    ld_last;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic last_one;
    logic pos_zero;
    logic left_in;
    logic right_in;
    logic up_better;
    logic dn_better;
    logic out_free;
  } stat_t;

  // True when a belongs above b: larger in max mode, smaller in min mode.
  function automatic logic ranks_above(input val_t a, input val_t b, input logic min_mode);
    logic res;
    if (min_mode) begin
      res = (a < b);
    end else begin
      res = (a > b);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bhpq_ram.sv
`default_nettype none
module bhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/bhpq_dp.sv
`default_nettype none
module bhpq_dp (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wen,
  input  wire logic                      cfg_wdata,
  input  wire logic                      in_op,
  input  wire logic [bhpq_pkg::IN_W-1:0] in_value,
  input  wire bhpq_pkg::cmd_t            cmd,
  output bhpq_pkg::stat_t                stat,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [bhpq_pkg::OUT_W-1:0]     out_tdata
);
  import bhpq_pkg::*;

  logic [CW-1:0]    fill_r, fill_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [AW-1:0]    cidx_r, cidx_nxt;
  val_t             cur_r, cur_nxt;
  val_t             child_r, child_nxt;
  val_t             top_r, top_nxt;
  val_t             removed_r, removed_nxt;
  status_t          st_r, st_nxt;
  logic             mode_r, mode_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;
  val_t             rd_val;
  logic [AW-1:0]    parent_idx;
  logic [IW-1:0]    left_idx, right_idx, fill_wide;
  logic             is_full, is_empty, right_better;
  val_t             top_out;

  assign rd_val     = val_t'(ram_rdata);
  assign parent_idx = (pos_r - AW'(1)) >> 1;
  assign left_idx   = {1'b0, pos_r, 1'b1};
  assign right_idx  = left_idx + IW'(1);
  assign fill_wide  = IW'(fill_r);
  assign is_full    = (fill_r == CW'(CAPACITY));
  assign is_empty   = (fill_r == '0);
  assign right_better = ranks_above(rd_val, child_r, mode_r);
  assign top_out    = is_empty ? val_t'(0) : top_r;

  assign stat.full      = is_full;
  assign stat.empty     = is_empty;
  assign stat.last_one  = (fill_r == CW'(1));
  assign stat.pos_zero  = (pos_r == '0);
  assign stat.left_in   = (left_idx < fill_wide);
  assign stat.right_in  = (right_idx < fill_wide);
  assign stat.up_better = ranks_above(cur_r, rd_val, mode_r);
  assign stat.dn_better = ranks_above(child_r, cur_r, mode_r);
  assign stat.out_free  = !out_valid_r || out_tready;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_PARENT: ram_raddr = parent_idx;
      RD_LAST:   ram_raddr = fill_r[AW-1:0];
      RD_LEFT:   ram_raddr = left_idx[AW-1:0];
      RD_RIGHT:  ram_raddr = right_idx[AW-1:0];
      default:   ram_raddr = '0;
    endcase
    ram_re = (cmd.rd_sel != RD_NONE);
  end

  always_comb begin
    unique case (cmd.wr_sel)
      WR_CUR:    ram_wdata = cur_r;
      WR_PARENT: ram_wdata = ram_rdata;
      WR_CHILD:  ram_wdata = child_r;
      default:   ram_wdata = '0;
    endcase
    ram_we = (cmd.wr_sel != WR_NONE);
  end

  bhpq_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    fill_nxt      = fill_r;
    pos_nxt       = pos_r;
    cidx_nxt      = cidx_r;
    cur_nxt       = cur_r;
    child_nxt     = child_r;
    top_nxt       = top_r;
    removed_nxt   = removed_r;
    st_nxt        = st_r;
    mode_nxt      = cfg_wen ? cfg_wdata : mode_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    if (cmd.accept) begin
      removed_nxt = '0;
      st_nxt      = ST_OK;
      if (op_t'(in_op) == OP_INSERT) begin
        if (is_full) begin
          st_nxt = ST_FULL;
        end else begin
          cur_nxt  = val_t'(in_value);
          pos_nxt  = fill_r[AW-1:0];
          fill_nxt = fill_r + CW'(1);
        end
      end else begin
        if (is_empty) begin
          st_nxt = ST_EMPTY;
        end else begin
          removed_nxt = top_r;
          fill_nxt    = fill_r - CW'(1);
        end
      end
    end

    if (cmd.ld_last) begin
      cur_nxt = rd_val;
      pos_nxt = '0;
    end

    if (cmd.cap_left) begin
      child_nxt = rd_val;
      cidx_nxt  = left_idx[AW-1:0];
    end

    if (cmd.cap_right && right_better) begin
      child_nxt = rd_val;
      cidx_nxt  = right_idx[AW-1:0];
    end

    if (ram_we && pos_r == '0) begin
      top_nxt = val_t'(ram_wdata);
    end

    if (cmd.wr_sel == WR_PARENT) begin
      pos_nxt = parent_idx;
    end else if (cmd.wr_sel == WR_CHILD) begin
      pos_nxt = cidx_r;
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {{(OUT_W - OUT_RAW){1'b0}}, COUNT_W'(fill_r), top_out, removed_r, st_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    cidx_r     <= cidx_nxt;
    cur_r      <= cur_nxt;
    child_r    <= child_nxt;
    top_r      <= top_nxt;
    removed_r  <= removed_nxt;
    st_r       <= st_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

FILE: rtl/core/bhpq_ctrl.sv
`default_nettype none
module bhpq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic            in_op,
  input  wire bhpq_pkg::stat_t stat,
  output bhpq_pkg::cmd_t       cmd
);
  import bhpq_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_UP_RD    = 10'b00_0000_0010,
    S_UP_CMP   = 10'b00_0000_0100,
    S_LAST_RD  = 10'b00_0000_1000,
    S_LAST_CAP = 10'b00_0001_0000,
    S_DN_L     = 10'b00_0010_0000,
    S_DN_LCAP  = 10'b00_0100_0000,
    S_DN_RCAP  = 10'b00_1000_0000,
    S_DN_CMP   = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.rd_sel    = RD_NONE;
    cmd.wr_sel    = WR_NONE;
    in_tready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (op_t'(in_op) == OP_INSERT) begin
            state_nxt = stat.full ? S_DONE : S_UP_RD;
          end else if (stat.empty || stat.last_one) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_LAST_RD;
          end
        end
      end
      S_UP_RD: begin
        if (stat.pos_zero) begin
          cmd.wr_sel = WR_CUR;
          state_nxt  = S_DONE;
        end else begin
          cmd.rd_sel = RD_PARENT;
          state_nxt  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_better) begin
          cmd.wr_sel = WR_PARENT;
          state_nxt  = S_UP_RD;
        end else begin
          cmd.wr_sel = WR_CUR;
          state_nxt  = S_DONE;
        end
      end
      S_LAST_RD: begin
        cmd.rd_sel = RD_LAST;
        state_nxt  = S_LAST_CAP;
      end
      S_LAST_CAP: begin
        cmd.ld_last = 1'b1;
        state_nxt   = S_DN_L;
      end
      S_DN_L: begin
        if (stat.left_in) begin
          cmd.rd_sel = RD_LEFT;
          state_nxt  = S_DN_LCAP;
        end else begin
          cmd.wr_sel = WR_CUR;
          state_nxt  = S_DONE;
        end
      end
      S_DN_LCAP: begin
        cmd.cap_left = 1'b1;
        if (stat.right_in) begin
          cmd.rd_sel = RD_RIGHT;
          state_nxt  = S_DN_RCAP;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_RCAP: begin
        cmd.cap_right = 1'b1;
        state_nxt     = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (stat.dn_better) begin
          cmd.wr_sel = WR_CHILD;
          state_nxt  = S_DN_L;
        end else begin
          cmd.wr_sel = WR_CUR;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/binary_heap_priority_queue.sv
// Priority queue of up to 64 signed 32-bit words held as a binary heap in a
// single-port-read RAM; cfg_wdata selects max-heap (0) or min-heap (1) and should
// be changed only while the queue is empty. Each input word is an insert or a
// remove-top and yields exactly one output word with status, removed value, new
// top and entry count. Each operation begins with the accepting step and ends
// with the step that loads the output register. The RAM read is registered, so
// each heap level moved when sifting up takes a parent read and a compare; a
// remove first reads the last entry and loads it at the root, and each level
// moved when sifting down takes a left-child read, a left capture, a right
// capture when both children exist, and a compare. An insert moves the word up
// at most 6 levels and a remove moves it down at most 5. A refused operation, or
// a remove that empties the queue, goes straight to loading the output register.
// A stalled output keeps the queue waiting until the output register is free.
// A new input word is taken as soon as the previous result is in the output
// register.
`default_nettype none
module binary_heap_priority_queue (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wen,
  input  wire logic                       cfg_wdata,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [bhpq_pkg::IN_W-1:0]  in_tdata,   // value
  input  wire logic                       in_tuser,   // opcode
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [bhpq_pkg::OUT_W-1:0]      out_tdata   // status, removed_value, top_value, entry_count
);
  import bhpq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  bhpq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_op      (in_tuser),
    .in_value   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

FILE: rtl/core/bhpq_checker.sv
`default_nettype none
module bhpq_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_tvalid,
  input wire logic                      out_tready,
  input wire logic [bhpq_pkg::OUT_W-1:0] out_tdata
);
  import bhpq_pkg::*;

  logic [ST_W-1:0]    o_st;
  logic [VAL_W-1:0]   o_removed;
  logic [VAL_W-1:0]   o_top;
  logic [COUNT_W-1:0] o_count;

  assign o_st      = out_tdata[ST_W-1:0];
  assign o_removed = out_tdata[ST_W+VAL_W-1:ST_W];
  assign o_top     = out_tdata[ST_W+2*VAL_W-1:ST_W+VAL_W];
  assign o_count   = out_tdata[OUT_RAW-1:ST_W+2*VAL_W];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Output word changed while stalled.");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (o_st == ST_OK || o_st == ST_FULL || o_st == ST_EMPTY))
    else $error("Output status code is undefined.");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_st == ST_FULL |-> o_count == COUNT_W'(CAPACITY) && o_removed == '0)
    else $error("Refused insert reported with a queue that is not full.");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_st == ST_EMPTY |-> o_count == '0 && o_top == '0 && o_removed == '0)
    else $error("Refused remove reported with a queue that is not empty.");

  a_zero_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_count == '0 |-> o_top == '0)
    else $error("Empty queue reported a non-zero top.");

endmodule

bind binary_heap_priority_queue bhpq_checker u_bhpq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
